### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rdq_pkg.sv
`timescale 1ns / 1ps

package rdq_pkg;

    localparam int DATA_W  = 32;
    localparam int CALL_W  = 16;
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 3;
    localparam int CFG_W   = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_TAIL_WRITE     = 3'd0,
        CMD_TAIL_OVERWRITE = 3'd1,
        CMD_HEAD_PUSH      = 3'd2,
        CMD_HEAD_READ      = 3'd3,
        CMD_CLEAR          = 3'd4
    } cmd_t;

    typedef struct packed {
        logic               is_full;
        logic               is_empty;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] item_count;
        logic [CALL_W-1:0]  accepted_in_call;
        logic [DATA_W-1:0]  read_data;
        logic               accepted;
    } result_t;

endpackage

### hdl/rdq_ring.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rdq_ring #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  rdq_pkg::cmd_t               cmd,
    input  logic [rdq_pkg::DATA_W-1:0]  data_in,
    input  logic                        last_in_call,
    input  logic                        cfg_we,
    input  logic [rdq_pkg::CFG_W-1:0]   cfg_data,
    output rdq_pkg::result_t            result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = (ELEMENT_BITS < rdq_pkg::DATA_W) ? ELEMENT_BITS : rdq_pkg::DATA_W;
    localparam int CW = rdq_pkg::COUNT_W;
    localparam int LW = ((IW > CW) ? IW : CW) + 1;
    localparam int KW = rdq_pkg::CALL_W;
    localparam int CAP_INT = (DEPTH > (2 ** CW) - 1) ? (2 ** CW) - 1 : DEPTH;
    localparam logic [CW-1:0] DEPTH_CAP = CW'(CAP_INT);

    logic [EW-1:0] mem [DEPTH];

    logic [CW-1:0] depth_reg;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          full_reg, full_next;
    logic [KW-1:0] call_reg, call_next;

    logic [EW-1:0] rd_mem_reg;
    logic          rd_sel_reg;
    logic          acc_reg;
    logic [KW-1:0] call_out_reg;
    logic [CW-1:0] items_reg;
    logic [CW-1:0] free_reg;
    logic          empty_reg;
    logic          full_out_reg;

    logic [IW-1:0] last_idx;
    logic [IW-1:0] head_inc, head_dec, tail_inc;
    logic          empty_now;
    logic          we;
    logic [IW-1:0] waddr;
    logic          acc;
    logic          rd_sel;
    logic          clr;
    logic [KW-1:0] call_out;
    logic [LW-1:0] depth_l, head_l, tail_l;
    logic [LW-1:0] items_l, free_l;
    logic          empty_next;
    logic [CW-1:0] cfg_depth;

    assign depth_l  = LW'(depth_reg);
    assign last_idx = IW'(depth_l - LW'(1));
    assign head_inc = (head_reg == last_idx) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? last_idx : head_reg - 1'b1;
    assign tail_inc = (tail_reg == last_idx) ? '0 : tail_reg + 1'b1;
    assign empty_now = (head_reg == tail_reg) && !full_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        full_next = full_reg;
        we        = 1'b0;
        waddr     = tail_reg;
        acc       = 1'b0;
        rd_sel    = 1'b0;
        clr       = 1'b0;
        case (cmd)
            rdq_pkg::CMD_TAIL_WRITE:
            begin
                if (!full_reg)
                begin
                    we        = 1'b1;
                    tail_next = tail_inc;
                    full_next = (tail_inc == head_reg);
                    acc       = 1'b1;
                end
            end
            rdq_pkg::CMD_TAIL_OVERWRITE:
            begin
                // when full the oldest element is dropped and the ring stays full
                if (full_reg)
                    head_next = head_inc;
                we        = 1'b1;
                tail_next = tail_inc;
                full_next = full_reg || (tail_inc == head_reg);
                acc       = 1'b1;
            end
            rdq_pkg::CMD_HEAD_PUSH:
            begin
                if (!full_reg)
                begin
                    we        = 1'b1;
                    waddr     = head_dec;
                    head_next = head_dec;
                    full_next = (head_dec == tail_reg);
                    acc       = 1'b1;
                end
            end
            rdq_pkg::CMD_HEAD_READ:
            begin
                if (!empty_now)
                begin
                    rd_sel    = 1'b1;
                    head_next = head_inc;
                    full_next = 1'b0;
                    acc       = 1'b1;
                end
            end
            rdq_pkg::CMD_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                full_next = 1'b0;
                acc       = 1'b1;
                clr       = 1'b1;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (clr)
            call_out = '0;
        else if (acc && (call_reg != '1))
            call_out = call_reg + 1'b1;
        else
            call_out = call_reg;
        call_next = last_in_call ? '0 : call_out;
    end

    assign head_l     = LW'(head_next);
    assign tail_l     = LW'(tail_next);
    assign empty_next = (head_next == tail_next) && !full_next;

    always_comb
    begin
        if (full_next)
            items_l = depth_l;
        else if (tail_l >= head_l)
            items_l = tail_l - head_l;
        else
            items_l = tail_l + depth_l - head_l;

        if (empty_next)
            free_l = depth_l;
        else if (head_l >= tail_l)
            free_l = head_l - tail_l;
        else
            free_l = head_l + depth_l - tail_l;
    end

    // a depth of zero behaves as one, anything above the ring size as the ring size
    assign cfg_depth = (cfg_data == '0) ? CW'(1) :
                       ((CW'(cfg_data) > DEPTH_CAP) ? DEPTH_CAP : CW'(cfg_data));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= DEPTH_CAP;
            head_reg     <= '0;
            tail_reg     <= '0;
            full_reg     <= 1'b0;
            call_reg     <= '0;
            rd_sel_reg   <= 1'b0;
            acc_reg      <= 1'b0;
            call_out_reg <= '0;
            items_reg    <= '0;
            free_reg     <= '0;
            empty_reg    <= 1'b1;
            full_out_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            depth_reg <= cfg_depth;
            head_reg  <= '0;
            tail_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else if (step)
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            full_reg     <= full_next;
            call_reg     <= call_next;
            rd_sel_reg   <= rd_sel;
            acc_reg      <= acc;
            call_out_reg <= call_out;
            items_reg    <= CW'(items_l);
            free_reg     <= CW'(free_l);
            empty_reg    <= empty_next;
            full_out_reg <= full_next;
        end
    end

    // element store; the read sees the contents before this transaction's write
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rd_mem_reg <= mem[head_reg];
            if (we)
                mem[waddr] <= data_in[EW-1:0];
        end
    end

    assign result.accepted         = acc_reg;
    assign result.read_data        = rd_sel_reg ? rdq_pkg::DATA_W'(rd_mem_reg) : '0;
    assign result.accepted_in_call = call_out_reg;
    assign result.item_count       = items_reg;
    assign result.free_count       = free_reg;
    assign result.is_empty         = empty_reg;
    assign result.is_full          = full_out_reg;

    `ASSERT_ALWAYS(a_full_idx_equal, !full_reg || (head_reg == tail_reg),
        "full flag set with head and tail apart")
    `ASSERT_ALWAYS(a_idx_in_ring, (LW'(head_reg) < depth_l) && (LW'(tail_reg) < depth_l),
        "index outside the ring in use")
    `ASSERT_NEXT(a_clear_empties, step && !cfg_we && (cmd == rdq_pkg::CMD_CLEAR),
        result.accepted && result.is_empty && (result.item_count == '0)
            && (result.accepted_in_call == '0),
        "clear did not leave an empty ring")

endmodule

### hdl/ring_deque_with_overwrite_unit.sv
`timescale 1ns / 1ps

// Ring deque with overwrite.
// Input stream (s_*): one element command per transaction; s_tuser carries the
// command, s_tdata the element and s_tlast closes a multi-element call.
// Output stream (m_*): exactly one result per input transaction, in order.
// Configuration channel (cfg_*): writes depth_in_use and empties the ring; it is
// always ready and is to be written only while no transaction is in flight.
// The element waits in the input register until the result register is free or
// being taken; the ring is then updated and the result register loaded at the same edge.
// Throughput: one transaction per cycle while the receiver takes each result; the
// ring indexes, full flag and call count are updated by combinational wrap logic,
// and the element store has one write and one registered read port.
// Reset empties the ring, zeroes the call count and sets depth_in_use to DEPTH
// (capped at 31); stored elements are not cleared.
// When the receiver stalls the result is held, the input register still takes
// one more transaction, and s_tready then falls until the result is taken.

module ring_deque_with_overwrite_unit #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rdq_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] data_in
    input  logic [rdq_pkg::CMD_W-1:0]         s_tuser,   // [2:0] cmd
    input  logic                              s_tlast,   // last_in_call

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] accepted, [32:1] read_data, [48:33] accepted_in_call,
    // [53:49] item_count, [58:54] free_count, [59] is_empty, [60] is_full
    output logic [rdq_pkg::OUT_TDATA_W-1:0]   m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdq_pkg::CFG_W-1:0]         cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    logic                          out_valid_reg, out_valid_next;
    rdq_pkg::cmd_t                 cmd_reg;
    logic [rdq_pkg::DATA_W-1:0]    data_reg;
    logic                          last_reg;
    logic                          out_free;
    logic                          step;
    logic                          s_accept;
    rdq_pkg::result_t              result;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg  <= rdq_pkg::cmd_t'(s_tuser);
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    rdq_ring #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cmd          (cmd_reg),
        .data_in      (data_reg),
        .last_in_call (last_reg),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result       (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       result.is_full,
                       result.is_empty,
                       result.free_count,
                       result.item_count,
                       result.accepted_in_call,
                       result.read_data,
                       result.accepted};

endmodule
